// ----- design/tcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcfd_pkg
// Shared types, codes and the frame-close kind lookup for the two-contact
// touch frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfd_pkg;

  // contact slots per frame
  localparam int unsigned MAX_CONTACTS = 2;
  localparam int unsigned SLOT_W       = $clog2(MAX_CONTACTS);
  localparam int unsigned DATA_W       = 32;

  // input word type codes
  localparam logic [2:0] MODE_SYNC    = 3'd0;
  localparam logic [2:0] MODE_KEY     = 3'd1;
  localparam logic [2:0] MODE_AXIS    = 3'd2;
  localparam logic [2:0] MODE_TIMEOUT = 3'd3;

  // absolute axis codes
  localparam logic [2:0] AXIS_MAJOR   = 3'd0;
  localparam logic [2:0] AXIS_POS_X   = 3'd1;
  localparam logic [2:0] AXIS_POS_Y   = 3'd2;
  localparam logic [2:0] AXIS_IGNORED = 3'd3;

  // slot event kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_AXIS = 2'd1;
  localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

  // configuration register index
  localparam logic REG_EVENT_ENABLE = 1'b0;

  // one job handed from the classifier to the emitter
  typedef struct packed {
    logic [1:0]                             status;
    logic [1:0]                             count;
    logic [MAX_CONTACTS-1:0][1:0]           kind;
    logic [MAX_CONTACTS-1:0]                emit;
    logic [MAX_CONTACTS-1:0][DATA_W-1:0]    pos_x;
    logic [MAX_CONTACTS-1:0][DATA_W-1:0]    pos_y;
    logic [MAX_CONTACTS-1:0][DATA_W-1:0]    major;
  } tcfd_job_t;

  // kind for a slot given previous and current frame counts
  function automatic logic [1:0] kind_lookup(input logic [1:0] prev_cnt,
                                             input logic [1:0] cur_cnt,
                                             input logic       slot);
    logic [1:0] k;
    if (!slot) begin
      if (prev_cnt == 2'd0) k = (cur_cnt == 2'd0) ? KIND_NONE : KIND_START;
      else                  k = (cur_cnt == 2'd0) ? KIND_END  : KIND_MOVE;
    end else begin
      if (prev_cnt == 2'd2) k = (cur_cnt == 2'd2) ? KIND_MOVE  : KIND_END;
      else                  k = (cur_cnt == 2'd2) ? KIND_START : KIND_NONE;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- design/tcfd_front.sv -----
// ----------------------------------------------------------------------------
// tcfd_front
// Accepts input words, tracks frame state and slot stores, and turns each
// frame close or error into a job for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfd_front import tcfd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_mode,
  input  wire logic [2:0]               in_axis_code,
  input  wire logic signed [DATA_W-1:0] in_axis_value,
  input  wire logic [3:0]               enable_mask,
  input  wire logic                     q_full,
  output logic                          q_push,
  output tcfd_job_t                     q_job
);

  logic [1:0]                          prior_r, prior_nxt;
  logic [1:0]                          cnt_r, cnt_nxt;
  logic                                sync_r, sync_nxt;
  logic                                key_r, key_nxt;
  logic [MAX_CONTACTS-1:0][DATA_W-1:0] x_r, x_nxt;
  logic [MAX_CONTACTS-1:0][DATA_W-1:0] y_r, y_nxt;
  logic [MAX_CONTACTS-1:0][DATA_W-1:0] maj_r, maj_nxt;

  logic                                accept;
  logic                                close;
  logic [1:0]                          err;
  logic                                room;
  logic [SLOT_W-1:0]                   wr_slot;
  logic [1:0]                          p_cnt;
  logic [1:0]                          c_cnt;
  logic [MAX_CONTACTS-1:0][1:0]        kinds;
  logic [MAX_CONTACTS-1:0]             emit;

  // stall whenever the job queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign room     = (cnt_r < 2'(MAX_CONTACTS));
  assign wr_slot  = cnt_r[SLOT_W-1:0];

  // classify the word
  always_comb begin
    close = 1'b0;
    err   = STATUS_OK;
    unique case (in_mode)
      MODE_SYNC:    close = sync_r;
      MODE_KEY:     close = 1'b0;
      MODE_AXIS:    if (in_axis_code > AXIS_IGNORED) err = STATUS_BAD_AXIS;
      MODE_TIMEOUT: close = 1'b1;
      default:      err = STATUS_BAD_TYPE;
    endcase
  end

  // frame-close kinds and enable filter
  assign p_cnt = (prior_r > 2'(MAX_CONTACTS)) ? 2'(MAX_CONTACTS) : prior_r;
  assign c_cnt = (cnt_r == 2'd0 && !key_r) ? p_cnt : cnt_r;

  always_comb begin
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      kinds[i] = kind_lookup(p_cnt, c_cnt, i[0]);
      emit[i]  = enable_mask[kinds[i]];
    end
  end

  // job build
  always_comb begin
    q_job = '0;
    if (err != STATUS_OK) begin
      q_job.status = err;
      q_job.emit   = MAX_CONTACTS'(1);
    end else begin
      q_job.status = STATUS_OK;
      q_job.count  = c_cnt;
      q_job.kind   = kinds;
      q_job.emit   = emit;
      q_job.pos_x  = x_r;
      q_job.pos_y  = y_r;
      q_job.major  = maj_r;
    end
  end

  assign q_push = accept && ((err != STATUS_OK) || (close && (emit != '0)));

  // next frame state
  always_comb begin
    prior_nxt = prior_r;
    cnt_nxt   = cnt_r;
    sync_nxt  = sync_r;
    key_nxt   = key_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    maj_nxt   = maj_r;
    if (accept && err == STATUS_OK) begin
      if (close) begin
        prior_nxt = c_cnt;
        cnt_nxt   = 2'd0;
        sync_nxt  = 1'b0;
        key_nxt   = 1'b0;
      end else begin
        unique case (in_mode)
          MODE_SYNC: sync_nxt = 1'b1;
          MODE_KEY:  key_nxt  = 1'b1;
          MODE_AXIS: begin
            if (in_axis_code == AXIS_MAJOR) begin
              if (room) maj_nxt[wr_slot] = in_axis_value;
              if (cnt_r != 2'd0) sync_nxt = 1'b0;
            end else if (in_axis_code == AXIS_POS_X) begin
              if (room) x_nxt[wr_slot] = in_axis_value;
            end else if (in_axis_code == AXIS_POS_Y) begin
              if (room) begin
                y_nxt[wr_slot] = in_axis_value;
                cnt_nxt        = cnt_r + 2'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
      cnt_r   <= '0;
      sync_r  <= 1'b0;
      key_r   <= 1'b0;
      x_r     <= '0;
      y_r     <= '0;
      maj_r   <= '0;
    end else begin
      prior_r <= prior_nxt;
      cnt_r   <= cnt_nxt;
      sync_r  <= sync_nxt;
      key_r   <= key_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      maj_r   <= maj_nxt;
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(MAX_CONTACTS))
    else $error("contact count above limit");

  a_prior_range: assert property (@(posedge clk) disable iff (!rst_n)
    prior_r <= 2'(MAX_CONTACTS))
    else $error("prior count above limit");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && close && err == STATUS_OK) |=> (cnt_r == 2'd0 && !sync_r && !key_r))
    else $error("frame close did not clear frame state");

endmodule

`default_nettype wire

// ----- design/tcfd_fifo.sv -----
// ----------------------------------------------------------------------------
// tcfd_fifo
// Small register queue of jobs between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfd_fifo import tcfd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  tcfd_job_t push_job,
  output logic      full,
  input  wire logic pop,
  output tcfd_job_t pop_job,
  output logic      not_empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tcfd_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = mem_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ----- design/tcfd_back.sv -----
// ----------------------------------------------------------------------------
// tcfd_back
// Takes jobs from the queue and presents their results one word per cycle
// while out_stall is low, slot 0 before slot 1.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfd_back import tcfd_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  tcfd_job_t                      q_job,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_event_kind,
  output logic [1:0]                     out_contact_count,
  output logic                           out_slot_index,
  output logic signed [DATA_W-1:0]       out_pos_x,
  output logic signed [DATA_W-1:0]       out_pos_y,
  output logic signed [DATA_W-1:0]       out_contact_major,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  tcfd_job_t         job_r, job_nxt;
  logic              busy_r, busy_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic              out_accept;

  assign out_accept = out_valid && !out_stall;
  assign q_pop      = q_valid && (!busy_r || (out_accept && out_last));

  // result fields straight from the held job
  assign out_valid         = busy_r;
  assign out_event_kind    = job_r.kind[sel_r];
  assign out_contact_count = job_r.count;
  assign out_slot_index    = sel_r;
  assign out_pos_x         = job_r.pos_x[sel_r];
  assign out_pos_y         = job_r.pos_y[sel_r];
  assign out_contact_major = job_r.major[sel_r];
  assign out_status        = job_r.status;
  assign out_last          = (sel_r == SLOT_W'(MAX_CONTACTS - 1)) || !job_r.emit[MAX_CONTACTS-1];

  // job load and slot advance
  always_comb begin
    job_nxt  = job_r;
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    if (q_pop) begin
      job_nxt  = q_job;
      busy_nxt = 1'b1;
      sel_nxt  = q_job.emit[0] ? '0 : SLOT_W'(MAX_CONTACTS - 1);
    end else if (out_accept) begin
      if (out_last) busy_nxt = 1'b0;
      else          sel_nxt  = SLOT_W'(MAX_CONTACTS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
    end
    job_r <= job_nxt;
  end

  // checks
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> out_last)
    else $error("error word not marked last");

  a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |->
      (out_event_kind == KIND_NONE && out_contact_count == 2'd0 && out_pos_x == '0))
    else $error("error word carries slot data");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_accept && !out_last) |=> (out_valid && sel_r == SLOT_W'(MAX_CONTACTS - 1)))
    else $error("second slot word did not follow");

endmodule

`default_nettype wire

// ----- design/two_contact_touch_frame_decoder.sv -----
// An accepted word goes into the job queue, then into the emitter's job
// register, before its first result shows. One input word per cycle while
// in_stall is low; a frame close with two enabled slot events gives two result
// words; FIFO_DEPTH queue entries absorb the difference before in_stall rises.
// Reset (rst_n low, synchronous) clears the enable mask, frame counts, flags,
// slot stores and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// two_contact_touch_frame_decoder
// Top level: configuration register, classifier, job queue and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module two_contact_touch_frame_decoder import tcfd_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_mode,
  input  wire logic [2:0]               in_axis_code,
  input  wire logic signed [DATA_W-1:0] in_axis_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [1:0]                    out_contact_count,
  output logic                          out_slot_index,
  output logic signed [DATA_W-1:0]      out_pos_x,
  output logic signed [DATA_W-1:0]      out_pos_y,
  output logic signed [DATA_W-1:0]      out_contact_major,
  output logic [1:0]                    out_status,
  output logic                          out_last,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [2:0]               cfg_paddr,
  input  wire logic [31:0]              cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [3:0] mask_r;
  logic       cfg_wr;
  tcfd_job_t  push_job;
  tcfd_job_t  pop_job;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_EVENT_ENABLE) ? {28'd0, mask_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_EVENT_ENABLE) begin
      mask_r <= cfg_pwdata[3:0];
    end
  end

  tcfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_axis_code  (in_axis_code),
    .in_axis_value (in_axis_value),
    .enable_mask   (mask_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  tcfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_valid)
  );

  tcfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_job             (pop_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_contact_count (out_contact_count),
    .out_slot_index    (out_slot_index),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_contact_major (out_contact_major),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives sync, key, axis and timeout words into the two-contact touch frame
// decoder and checks every frame-close and error result against a predictor
// that tracks the frame counts, flags, slot stores and enable mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tcfd_pkg::*;

  // word codes the package leaves unnamed
  localparam logic [2:0] MODE_UNKNOWN = 3'd4;
  localparam logic [2:0] AXIS_UNKNOWN = 3'd4;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  count;
    logic        slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] major;
    logic [1:0]  status;
    logic        last;
  } touch_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = MODE_SYNC;
  logic [2:0]  in_axis_code = AXIS_MAJOR;
  logic signed [31:0] in_axis_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [1:0]  out_contact_count;
  logic        out_slot_index;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_contact_major;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  logic [3:0]  enable_mask;
  logic [1:0]  prior_count;
  logic [1:0]  cur_count;
  logic        sync_seen;
  logic        key_seen;
  logic [31:0] slot_x [MAX_CONTACTS];
  logic [31:0] slot_y [MAX_CONTACTS];
  logic [31:0] slot_major [MAX_CONTACTS];

  touch_result_t pending_results[$];
  int mismatches = 0;
  int words_sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int stall_left = 0;

  two_contact_touch_frame_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_axis_code(in_axis_code), .in_axis_value(in_axis_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_kind(out_event_kind), .out_contact_count(out_contact_count),
    .out_slot_index(out_slot_index), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_contact_major(out_contact_major), .out_status(out_status),
    .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // values biased toward the extremes of a signed 32-bit field
  function automatic logic [31:0] axis_sample();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // a slot is live in a frame when the frame holds more contacts than its index
  function automatic logic [1:0] slot_kind(input logic [1:0] prev_cnt,
                                           input logic [1:0] cnt, input int s);
    logic was_live;
    logic is_live;
    was_live = prev_cnt > s;
    is_live = cnt > s;
    if (was_live && is_live) return KIND_MOVE;
    if (was_live) return KIND_END;
    if (is_live) return KIND_START;
    return KIND_NONE;
  endfunction

  function automatic void predictor_reset();
    enable_mask = 4'd0;
    prior_count = 2'd0;
    cur_count = 2'd0;
    sync_seen = 1'b0;
    key_seen = 1'b0;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      slot_x[i] = '0;
      slot_y[i] = '0;
      slot_major[i] = '0;
    end
  endfunction

  function automatic void push_error(input logic [1:0] code);
    touch_result_t r;
    r = '{kind: KIND_NONE, count: 2'd0, slot: 1'b0, x: '0, y: '0, major: '0,
          status: code, last: 1'b1};
    pending_results.push_back(r);
  endfunction

  // frame close: slot events filtered by the mask, last flag on the final one
  function automatic void close_frame();
    touch_result_t frame_out [MAX_CONTACTS];
    logic [1:0] cnt;
    logic [1:0] kind;
    int n;
    n = 0;
    cnt = cur_count;
    if (cnt == 2'd0 && !key_seen) cnt = prior_count;
    for (int s = 0; s < MAX_CONTACTS; s++) begin
      kind = slot_kind(prior_count, cnt, s);
      if (enable_mask[kind]) begin
        frame_out[n] = '{kind: kind, count: cnt, slot: s[0], x: slot_x[s],
                         y: slot_y[s], major: slot_major[s], status: STATUS_OK,
                         last: 1'b0};
        n++;
      end
    end
    if (n > 0) frame_out[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(frame_out[i]);
    prior_count = cnt;
    cur_count = 2'd0;
    sync_seen = 1'b0;
    key_seen = 1'b0;
  endfunction

  function automatic void predict_word(input logic [2:0] mode, input logic [2:0] code,
                                       input logic [31:0] value);
    logic room;
    room = cur_count < MAX_CONTACTS;
    case (mode)
      MODE_SYNC: begin
        if (sync_seen) close_frame();
        else sync_seen = 1'b1;
      end
      MODE_KEY: key_seen = 1'b1;
      MODE_AXIS: begin
        case (code)
          AXIS_MAJOR: begin
            if (room) slot_major[cur_count[0]] = value;
            if (cur_count != 2'd0) sync_seen = 1'b0;
          end
          AXIS_POS_X: if (room) slot_x[cur_count[0]] = value;
          AXIS_POS_Y: begin
            if (room) begin
              slot_y[cur_count[0]] = value;
              cur_count = cur_count + 2'd1;
            end
          end
          AXIS_IGNORED: ;
          default: push_error(STATUS_BAD_AXIS);
        endcase
      end
      MODE_TIMEOUT: close_frame();
      default: push_error(STATUS_BAD_TYPE);
    endcase
  endfunction

  // send one word, with an optional idle gap before it
  task automatic send_word(input logic [2:0] mode, input logic [2:0] code,
                           input logic [31:0] value);
    int gap;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_axis_code <= code;
    in_axis_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(mode, code, value);
    words_sent++;
  endtask

  task automatic send_axis(input logic [2:0] code, input logic [31:0] value);
    send_word(MODE_AXIS, code, value);
  endtask

  task automatic send_ctrl(input logic [2:0] mode);
    send_word(mode, 3'($urandom), axis_sample());
  endtask

  // hold the sender until every expected result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the enable mask while idle, then read it back
  task automatic write_enable_mask(input logic [3:0] value);
    drain();
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_EVENT_ENABLE, 2'b00};
    cfg_pwdata <= {28'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    enable_mask = value;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwdata <= 32'($urandom);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {28'd0, value}) begin
      $error("event_enable_mask readback: expected %0h, actual %0h", value, cfg_prdata);
      mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!rx_calm && $urandom_range(0, 2) == 0) stall_left = idle_len();
    out_stall <= (stall_left > 0);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    touch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d status %0d",
               out_event_kind, out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(out_event_kind));
        check_field("contact_count", 32'(want.count), 32'(out_contact_count));
        check_field("slot_index", 32'(want.slot), 32'(out_slot_index));
        check_field("pos_x", want.x, out_pos_x);
        check_field("pos_y", want.y, out_pos_y);
        check_field("contact_major", want.major, out_contact_major);
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // mask is zero out of reset: closes are silent, errors still report
  task automatic test_reset_mask();
    send_ctrl(MODE_TIMEOUT);
    send_ctrl(MODE_SYNC);
    send_axis(AXIS_MAJOR, 32'd17);
    send_ctrl(MODE_SYNC);
    send_ctrl(3'd7);
  endtask

  // hand-built frames through every kind transition
  task automatic test_frame_sequences();
    send_ctrl(MODE_SYNC);
    send_ctrl(MODE_SYNC);
    // single contact at the field extremes
    send_axis(AXIS_MAJOR, 32'h7fff_ffff);
    send_axis(AXIS_POS_X, 32'h8000_0000);
    send_axis(AXIS_POS_Y, 32'hffff_ffff);
    send_ctrl(MODE_SYNC);
    send_ctrl(MODE_SYNC);
    // two contacts plus a third that saturates and is dropped
    send_axis(AXIS_MAJOR, 32'd0);
    send_axis(AXIS_POS_X, 32'd1);
    send_axis(AXIS_POS_Y, 32'd2);
    send_axis(AXIS_MAJOR, 32'h5555_aaaa);
    send_axis(AXIS_POS_X, 32'haaaa_5555);
    send_axis(AXIS_POS_Y, 32'h0000_ffff);
    send_axis(AXIS_MAJOR, 32'hdead_0001);
    send_axis(AXIS_POS_X, 32'hdead_0002);
    send_axis(AXIS_POS_Y, 32'hdead_0003);
    send_axis(AXIS_IGNORED, 32'hffff_ffff);
    send_ctrl(MODE_SYNC);
    // contact size after contacts reopens the frame
    send_axis(AXIS_MAJOR, 32'hffff_fffb);
    send_ctrl(MODE_SYNC);
    send_ctrl(MODE_SYNC);
    // empty timeout keeps the previous count
    send_ctrl(MODE_TIMEOUT);
    // key with no contacts ends both slots
    send_ctrl(MODE_KEY);
    send_ctrl(MODE_TIMEOUT);
  endtask

  task automatic test_error_words();
    send_axis(AXIS_UNKNOWN, 32'h1234_5678);
    send_axis(3'd7, 32'hffff_ffff);
    send_word(MODE_UNKNOWN, AXIS_POS_Y, 32'h8000_0000);
    send_word(3'd7, AXIS_MAJOR, 32'd0);
  endtask

  // one frame: random contacts with random content, some noise, some breakage
  task automatic random_frame();
    int contacts;
    int r;
    r = $urandom_range(0, 19);
    contacts = (r < 3) ? 0 : (r < 9) ? 1 : (r < 18) ? 2 : 3;
    for (int c = 0; c < contacts; c++) begin
      if ($urandom_range(0, 9) != 0) send_axis(AXIS_MAJOR, axis_sample());
      send_axis(AXIS_POS_X, axis_sample());
      if ($urandom_range(0, 9) == 0) send_axis(AXIS_IGNORED, axis_sample());
      send_axis(AXIS_POS_Y, axis_sample());
      if ($urandom_range(0, 2) == 0) send_ctrl(MODE_SYNC);
    end
    if ($urandom_range(0, 4) == 0) send_ctrl(MODE_KEY);
    if ($urandom_range(0, 11) == 0) begin
      send_word(3'($urandom_range(4, 7)), 3'($urandom), axis_sample());
    end
    if ($urandom_range(0, 11) == 0) begin
      send_axis(3'($urandom_range(4, 7)), axis_sample());
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      send_ctrl(MODE_SYNC);
      send_ctrl(MODE_SYNC);
    end else if (r < 9) begin
      send_ctrl(MODE_TIMEOUT);
    end else if ($urandom_range(0, 1) == 0) begin
      send_word(3'($urandom), 3'($urandom), axis_sample());
    end
  endtask

  task automatic test_random_phase(input logic [3:0] mask, input int words);
    int stop_at;
    write_enable_mask(mask);
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 7) == 0) rx_calm = ~rx_calm;
      if ($urandom_range(0, 39) == 0) drain();
      random_frame();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    predictor_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_mask();
    write_enable_mask(4'hf);
    test_frame_sequences();
    test_error_words();
    test_random_phase(4'hf, 220);
    test_random_phase(4'h0, 120);
    test_random_phase(4'b0110, 170);
    test_random_phase(4'b1001, 170);
    test_random_phase(4'($urandom), 170);
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
